FILE: rtl/assert_macros.svh
// Assertion shorthands for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMP(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NXT(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/ldm_pkg.sv
package ldm_pkg;

	localparam logic [2:0] REASON_UNAVAIL = 3'd0;
	localparam logic [2:0] REASON_PHASE   = 3'd1;
	localparam logic [2:0] REASON_BITE    = 3'd2;
	localparam logic [2:0] REASON_CONTAM  = 3'd3;
	localparam logic [2:0] REASON_LOW     = 3'd4;
	localparam logic [2:0] REASON_MIXED   = 3'd5;
	localparam logic [2:0] REASON_DEADBND = 3'd6;
	localparam logic [2:0] REASON_ACTIVE  = 3'd7;

	localparam logic signed [15:0] Q_ONE_S  = 16'sd16384;
	localparam logic signed [15:0] Q_MONE_S = -16'sd16384;
	localparam logic [14:0] Q_ONE        = 15'd16384;
	localparam logic [14:0] ACT_FLOOR    = 15'd1311;
	localparam logic [14:0] BAL_DEADBAND = 15'd328;
	localparam logic [13:0] AW_DIV       = 14'd2785;
	localparam logic [13:0] BW_DIV       = 14'd16056;
	localparam logic [18:0] BW_RECIP     = 19'd267499;
	localparam logic [20:0] AW_RECIP     = 21'd1542178;
	localparam logic signed [26:0] MOD_CEILING = 27'sd655;

	localparam int unsigned LATENCY = 8;

	typedef struct packed {
		logic                avail;
		logic signed [15:0]  bal;
		logic [14:0]         act;
		logic                rel;
		logic [2:0]          reason;
		logic                mod_path;
		logic                bal_neg;
		logic [14:0]         conf;
		logic signed [15:0]  m4;
		logic signed [15:0]  legacy;
	} ldm_side_t;

endpackage

FILE: rtl/lateral_drive_modulator.sv
// A request passes stages s1 to s7; the output registers then give its result with done high.
// Throughput: one request per cycle through an eight-stage multiplier pipeline; busy stays low.
// The receiver cannot stall; every result is shown for exactly one cycle.
// Reset (arst_n low, asynchronous) clears all stage valid bits and done; no clearing pass.
`include "assert_macros.svh"

module lateral_drive_modulator import ldm_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic               context_available,
	input  logic signed [15:0] balance_in,
	input  logic signed [15:0] level_in,
	input  logic               bite_active,
	input  logic               recovery_not_baseline,
	input  logic               grip_emerging,
	input  logic               surface_fouled,
	input  logic               context_active,
	input  logic               response_mixed,
	input  logic signed [15:0] confidence_in,
	input  logic signed [15:0] m4_drive,
	input  logic signed [15:0] legacy_drive,
	output logic               done,
	output logic               frame_available,
	output logic signed [15:0] balance_out,
	output logic [14:0]        activity_out,
	output logic               release_phase,
	output logic [2:0]         reason,
	output logic signed [10:0] modulation,
	output logic signed [15:0] shadow_drive,
	output logic               limiter_hit,
	output logic signed [16:0] shadow_delta,
	output logic               drive_changed
);

	logic               accept;
	logic               valid_s1;
	logic               valid_s3;
	logic               valid_s6;
	ldm_side_t          side_s1;
	ldm_side_t          side_s3;
	ldm_side_t          side_s6;
	logic [13:0]        db_s1;
	logic [11:0]        da_s1;
	logic               da_sat_s1;
	logic signed [15:0] bw_s3;
	logic [14:0]        aw_s3;
	logic signed [10:0] mod_s6;

	assign busy   = 1'b0;
	assign accept = start & ~busy;

	ldm_front u_front (
		.clk                   (clk),
		.arst_n                (arst_n),
		.in_valid              (accept),
		.context_available     (context_available),
		.balance_in            (balance_in),
		.level_in              (level_in),
		.bite_active           (bite_active),
		.recovery_not_baseline (recovery_not_baseline),
		.grip_emerging         (grip_emerging),
		.surface_fouled        (surface_fouled),
		.context_active        (context_active),
		.response_mixed        (response_mixed),
		.confidence_in         (confidence_in),
		.m4_drive              (m4_drive),
		.legacy_drive          (legacy_drive),
		.valid_s1              (valid_s1),
		.side_s1               (side_s1),
		.db_s1                 (db_s1),
		.da_s1                 (da_s1),
		.da_sat_s1             (da_sat_s1)
	);

	ldm_weight u_weight (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid_s1  (valid_s1),
		.side_s1   (side_s1),
		.db_s1     (db_s1),
		.da_s1     (da_s1),
		.da_sat_s1 (da_sat_s1),
		.valid_s3  (valid_s3),
		.side_s3   (side_s3),
		.bw_s3     (bw_s3),
		.aw_s3     (aw_s3)
	);

	ldm_modchain u_modchain (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s3 (valid_s3),
		.side_s3  (side_s3),
		.bw_s3    (bw_s3),
		.aw_s3    (aw_s3),
		.valid_s6 (valid_s6),
		.side_s6  (side_s6),
		.mod_s6   (mod_s6)
	);

	ldm_limit u_limit (
		.clk             (clk),
		.arst_n          (arst_n),
		.valid_s6        (valid_s6),
		.side_s6         (side_s6),
		.mod_s6          (mod_s6),
		.done            (done),
		.frame_available (frame_available),
		.balance_out     (balance_out),
		.activity_out    (activity_out),
		.release_phase   (release_phase),
		.reason          (reason),
		.modulation      (modulation),
		.shadow_drive    (shadow_drive),
		.limiter_hit     (limiter_hit),
		.shadow_delta    (shadow_delta),
		.drive_changed   (drive_changed)
	);

	`ASSERT_NXT(a_accept_enters, clk, arst_n, accept, valid_s1,
		"Accepted request did not enter the first stage.")
	`ASSERT_IMP(a_changed_active, clk, arst_n, done && drive_changed,
		reason == REASON_ACTIVE && shadow_delta != 17'sd0,
		"A changed drive must report the active reason.")
	`ASSERT_IMP(a_unavail_pass, clk, arst_n, done && !frame_available,
		reason == REASON_UNAVAIL && shadow_delta == 17'sd0 &&
		shadow_drive == $past(m4_drive, LATENCY),
		"Unavailable context must pass the drive through.")
	`ASSERT_IMP(a_limit_gated, clk, arst_n, done && limiter_hit,
		frame_available && release_phase &&
		(reason == REASON_DEADBND || reason == REASON_ACTIVE),
		"Limiter flagged outside the modulation path.")

endmodule

FILE: rtl/ldm_front.sv
module ldm_front import ldm_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               context_available,
	input  logic signed [15:0] balance_in,
	input  logic signed [15:0] level_in,
	input  logic               bite_active,
	input  logic               recovery_not_baseline,
	input  logic               grip_emerging,
	input  logic               surface_fouled,
	input  logic               context_active,
	input  logic               response_mixed,
	input  logic signed [15:0] confidence_in,
	input  logic signed [15:0] m4_drive,
	input  logic signed [15:0] legacy_drive,
	output logic               valid_s1,
	output ldm_side_t          side_s1,
	output logic [13:0]        db_s1,
	output logic [11:0]        da_s1,
	output logic               da_sat_s1
);

	logic signed [15:0] bal_c;
	logic signed [15:0] bal_neg;
	logic [14:0]        act_c;
	logic [14:0]        conf_c;
	logic [14:0]        mag;
	logic [13:0]        db;
	logic [13:0]        da;
	ldm_side_t          side;

	always_comb begin
		if (balance_in > Q_ONE_S) begin
			bal_c = Q_ONE_S;
		end else if (balance_in < Q_MONE_S) begin
			bal_c = Q_MONE_S;
		end else begin
			bal_c = balance_in;
		end
		if (level_in[15]) begin
			act_c = '0;
		end else if (level_in > Q_ONE_S) begin
			act_c = Q_ONE;
		end else begin
			act_c = level_in[14:0];
		end
		if (confidence_in[15]) begin
			conf_c = '0;
		end else if (confidence_in > Q_ONE_S) begin
			conf_c = Q_ONE;
		end else begin
			conf_c = confidence_in[14:0];
		end
	end

	assign bal_neg = -bal_c;
	assign mag     = bal_c[15] ? bal_neg[14:0] : bal_c[14:0];
	assign db      = 14'(mag - BAL_DEADBAND);
	assign da      = 14'(act_c - ACT_FLOOR);

	always_comb begin
		side          = '0;
		side.m4       = m4_drive;
		side.legacy   = legacy_drive;
		side.conf     = conf_c;
		side.bal_neg  = bal_c[15];
		side.reason   = REASON_UNAVAIL;
		if (context_available) begin
			side.avail = 1'b1;
			side.bal   = bal_c;
			side.act   = act_c;
			if (bite_active || recovery_not_baseline) begin
				side.reason = REASON_BITE;
			end else if (!grip_emerging) begin
				side.reason = REASON_PHASE;
			end else begin
				side.rel = 1'b1;
				if (surface_fouled) begin
					side.reason = REASON_CONTAM;
				end else if (!context_active || act_c <= ACT_FLOOR) begin
					side.reason = REASON_LOW;
				end else if (response_mixed) begin
					side.reason = REASON_MIXED;
				end else begin
					side.reason   = REASON_DEADBND;
					side.mod_path = (mag > BAL_DEADBAND);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		side_s1   <= side;
		db_s1     <= db;
		da_s1     <= da[11:0];
		da_sat_s1 <= (da >= AW_DIV);
	end

endmodule

FILE: rtl/ldm_weight.sv
module ldm_weight import ldm_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               valid_s1,
	input  ldm_side_t          side_s1,
	input  logic [13:0]        db_s1,
	input  logic [11:0]        da_s1,
	input  logic               da_sat_s1,
	output logic               valid_s3,
	output ldm_side_t          side_s3,
	output logic signed [15:0] bw_s3,
	output logic [14:0]        aw_s3
);

	logic        valid_s2;
	ldm_side_t   side_s2;
	logic [13:0] db_s2;
	logic [11:0] da_s2;
	logic        da_sat_s2;
	logic [14:0] qb_s2;
	logic [14:0] qa_s2;
	logic [32:0] pb;
	logic [32:0] pa;
	logic [28:0] rb;
	logic [28:0] ra;
	logic [14:0] bw_mag;
	logic [14:0] aw_q;
	logic signed [15:0] bw_pos;

	assign pb = 33'(db_s1) * 33'(BW_RECIP);
	assign pa = 33'(da_s1) * 33'(AW_RECIP);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		side_s2   <= side_s1;
		db_s2     <= db_s1;
		da_s2     <= da_s1;
		da_sat_s2 <= da_sat_s1;
		qb_s2     <= pb[32:18];
		qa_s2     <= pa[32:18];
	end

	assign rb     = {1'b0, db_s2, 14'd0} - 29'(qb_s2) * 29'(BW_DIV);
	assign ra     = {3'd0, da_s2, 14'd0} - 29'(qa_s2) * 29'(AW_DIV);
	assign bw_mag = qb_s2 + 15'(rb >= 29'(BW_DIV));
	assign aw_q   = da_sat_s2 ? Q_ONE : qa_s2 + 15'(ra >= 29'(AW_DIV));
	assign bw_pos = {1'b0, bw_mag};

	always_ff @(posedge clk) begin
		side_s3 <= side_s2;
		bw_s3   <= side_s2.bal_neg ? -bw_pos : bw_pos;
		aw_s3   <= aw_q;
	end

endmodule

FILE: rtl/ldm_modchain.sv
module ldm_modchain import ldm_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               valid_s3,
	input  ldm_side_t          side_s3,
	input  logic signed [15:0] bw_s3,
	input  logic [14:0]        aw_s3,
	output logic               valid_s6,
	output ldm_side_t          side_s6,
	output logic signed [10:0] mod_s6
);

	logic               valid_s4;
	logic               valid_s5;
	ldm_side_t          side_s4;
	ldm_side_t          side_s5;
	logic [14:0]        aw_s4;
	logic signed [10:0] mod_s4;
	logic signed [10:0] mod_s5;
	logic signed [26:0] p1;
	logic signed [26:0] p2;
	logic signed [26:0] p3;

	assign p1 = MOD_CEILING * {{11{bw_s3[15]}}, bw_s3};
	assign p2 = {{16{mod_s4[10]}}, mod_s4} * $signed({12'd0, aw_s4});
	assign p3 = {{16{mod_s5[10]}}, mod_s5} * $signed({12'd0, side_s5.conf});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
		end else begin
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
			valid_s6 <= valid_s5;
		end
	end

	always_ff @(posedge clk) begin
		side_s4 <= side_s3;
		aw_s4   <= aw_s3;
		mod_s4  <= p1[24:14];
		side_s5 <= side_s4;
		mod_s5  <= p2[24:14];
		side_s6 <= side_s5;
		mod_s6  <= p3[24:14];
	end

endmodule

FILE: rtl/ldm_limit.sv
module ldm_limit import ldm_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               valid_s6,
	input  ldm_side_t          side_s6,
	input  logic signed [10:0] mod_s6,
	output logic               done,
	output logic               frame_available,
	output logic signed [15:0] balance_out,
	output logic [14:0]        activity_out,
	output logic               release_phase,
	output logic [2:0]         reason,
	output logic signed [10:0] modulation,
	output logic signed [15:0] shadow_drive,
	output logic               limiter_hit,
	output logic signed [16:0] shadow_delta,
	output logic               drive_changed
);

	logic               valid_s7;
	ldm_side_t          side_s7;
	logic signed [10:0] mod_s7;
	logic signed [17:0] cand_s7;
	logic signed [15:0] factor;
	logic signed [31:0] p4;
	logic signed [16:0] leg_ext;
	logic signed [17:0] lim;
	logic signed [17:0] lmt_a;
	logic signed [17:0] lmt_b;
	logic signed [16:0] delta;
	logic               modded;

	assign factor = Q_ONE_S + {{5{mod_s6[10]}}, mod_s6};
	assign p4     = {{16{side_s6.m4[15]}}, side_s6.m4} * {{16{factor[15]}}, factor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s7 <= 1'b0;
			done     <= 1'b0;
		end else begin
			valid_s7 <= valid_s6;
			done     <= valid_s7;
		end
	end

	always_ff @(posedge clk) begin
		side_s7 <= side_s6;
		mod_s7  <= mod_s6;
		cand_s7 <= p4[31:14];
	end

	assign leg_ext = {side_s7.legacy[15], side_s7.legacy};
	assign lim     = leg_ext[16] ? 18'(-leg_ext) : 18'(leg_ext);

	always_comb begin
		if (cand_s7 > lim) begin
			lmt_a = lim;
		end else if (cand_s7 < -lim) begin
			lmt_a = -lim;
		end else begin
			lmt_a = cand_s7;
		end
		if (lmt_a > 18'sd32767) begin
			lmt_b = 18'sd32767;
		end else if (lmt_a < -18'sd32768) begin
			lmt_b = -18'sd32768;
		end else begin
			lmt_b = lmt_a;
		end
	end

	assign delta  = lmt_b[16:0] - {side_s7.m4[15], side_s7.m4};
	assign modded = side_s7.mod_path;

	always_ff @(posedge clk) begin
		frame_available <= side_s7.avail;
		balance_out     <= side_s7.bal;
		activity_out    <= side_s7.act;
		release_phase   <= side_s7.rel;
		if (modded) begin
			modulation    <= mod_s7;
			shadow_drive  <= lmt_b[15:0];
			limiter_hit   <= (lmt_b != cand_s7);
			shadow_delta  <= delta;
			drive_changed <= (delta != 17'sd0);
			reason        <= (delta != 17'sd0) ? REASON_ACTIVE : REASON_DEADBND;
		end else begin
			modulation    <= '0;
			shadow_drive  <= side_s7.m4;
			limiter_hit   <= 1'b0;
			shadow_delta  <= '0;
			drive_changed <= 1'b0;
			reason        <= side_s7.reason;
		end
	end

endmodule
